// ===== sv/swoi_pkg.sv =====
// shared types and constants for the argsort block
// used by swoi_ctrl, swoi_cells and sort_with_original_indices
`timescale 1ns / 1ps
`default_nettype none

package swoi_pkg;

  localparam int VAL_W         = 64;
  localparam int POS_W         = 6;
  localparam int MAX_ITEMS_DEF = 64;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic insert;
    logic shift;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_cap;
    logic one_left;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/swoi_ctrl.sv =====
// batch controller: fill phase takes input beats, drain phase emits results
// depends on swoi_pkg
`timescale 1ns / 1ps
`default_nettype none

module swoi_ctrl
  import swoi_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic batch_end_i,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      in_stall_o,
  output logic      out_valid_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL: begin
        if (in_valid_i && (batch_end_i || sts_i.at_cap)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!out_stall_i && sts_i.one_left) begin
          state_d = ST_FILL;
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_FILL: begin
        in_stall_o   = 1'b0;
        cmd_o.insert = in_valid_i;
      end
      ST_DRAIN: begin
        out_valid_o = 1'b1;
        cmd_o.shift = !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/swoi_cells.sv =====
// row of insertion cells holding value, arrival position and valid per slot
// depends on swoi_pkg; driven by commands from swoi_ctrl
`timescale 1ns / 1ps
`default_nettype none

module swoi_cells
  import swoi_pkg::*;
#(
  parameter int MaxItems = MAX_ITEMS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cmd_t                    cmd_i,
  input  wire logic signed [VAL_W-1:0] sample_value_i,
  output sts_t                         sts_o,
  output logic signed [VAL_W-1:0]      head_value_o,
  output logic        [POS_W-1:0]      head_pos_o
);

  localparam int CntW = $clog2(MaxItems + 1);

  logic signed [VAL_W-1:0] val_q [MaxItems];
  logic signed [VAL_W-1:0] val_d [MaxItems];
  logic        [POS_W-1:0] pos_q [MaxItems];
  logic        [POS_W-1:0] pos_d [MaxItems];
  logic [MaxItems-1:0]     vld_q, vld_d;
  logic [MaxItems-1:0]     gt;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [POS_W-1:0]        new_pos;

  assign new_pos = POS_W'(cnt_q);

  // empty cells act as larger than any value, so new entries land after equals
  always_comb begin
    for (int i = 0; i < MaxItems; i++) begin
      gt[i] = !vld_q[i] || (val_q[i] > sample_value_i);
    end
  end

  always_comb begin
    for (int i = 0; i < MaxItems; i++) begin
      val_d[i] = val_q[i];
      pos_d[i] = pos_q[i];
      vld_d[i] = vld_q[i];
      if (cmd_i.insert) begin
        if (gt[i]) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            val_d[i] = val_q[(i > 0) ? i - 1 : 0];
            pos_d[i] = pos_q[(i > 0) ? i - 1 : 0];
            vld_d[i] = vld_q[(i > 0) ? i - 1 : 0];
          end else begin
            val_d[i] = sample_value_i;
            pos_d[i] = new_pos;
            vld_d[i] = 1'b1;
          end
        end
      end else if (cmd_i.shift) begin
        if (i < MaxItems - 1) begin
          val_d[i] = val_q[(i < MaxItems - 1) ? i + 1 : i];
          pos_d[i] = pos_q[(i < MaxItems - 1) ? i + 1 : i];
          vld_d[i] = vld_q[(i < MaxItems - 1) ? i + 1 : i];
        end else begin
          vld_d[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.insert) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd_i.shift) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cnt_q <= '0;
    end else begin
      vld_q <= vld_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert || cmd_i.shift) begin
      val_q <= val_d;
      pos_q <= pos_d;
    end
  end

  assign sts_o.at_cap   = (cnt_q == CntW'(MaxItems - 1));
  assign sts_o.one_left = (cnt_q == CntW'(1));
  assign head_value_o   = val_q[0];
  assign head_pos_o     = pos_q[0];

endmodule

`default_nettype wire

// ===== sv/sort_with_original_indices.sv =====
// top level of the argsort block: ascending sort with arrival positions
// depends on swoi_pkg, swoi_ctrl and swoi_cells
`timescale 1ns / 1ps
`default_nettype none

// During the fill phase one input beat is taken every cycle; each value drops
// straight into its sorted slot in a row of MaxItems compare cells, so there is
// no separate sort pass. A batch closes on a beat with batch_end_i set, or
// silently on the beat that fills the last cell. The block then emits the n
// held values smallest first, one result beat per cycle while out_stall_i is
// low, equal values by ascending arrival position, with final_result_o on the
// last one. No input is taken while draining, so a new batch cannot start
// until every value of the last one has come out.
module sort_with_original_indices
  import swoi_pkg::*;
#(
  parameter int MaxItems = MAX_ITEMS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic signed [VAL_W-1:0] sample_value_i,
  input  wire logic                    batch_end_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [VAL_W-1:0]      sorted_value_o,
  output logic        [POS_W-1:0]      origin_position_o,
  output logic                         final_result_o
);

  cmd_t cmd;
  sts_t sts;

  swoi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .batch_end_i (batch_end_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  swoi_cells #(
    .MaxItems (MaxItems)
  ) u_cells (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sample_value_i (sample_value_i),
    .sts_o          (sts),
    .head_value_o   (sorted_value_o),
    .head_pos_o     (origin_position_o)
  );

  // last beat of the batch when only the head cell is still held
  assign final_result_o = sts.one_left;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// testbench for sort_with_original_indices: batches of signed values, checked
// against an insertion-sort predictor; depends on swoi_pkg and the block's rtl
`timescale 1ns / 1ps

module tb;
  import swoi_pkg::*;

  localparam int CAP   = MAX_ITEMS_DEF;
  localparam int LIMIT = 200000;
  localparam logic signed [VAL_W-1:0] MAXV = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] MINV = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } sample_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
    logic                    fin;
  } sorted_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_stall_o;
  logic signed [VAL_W-1:0] sample_value_i = '0;
  logic                    batch_end_i    = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i    = 1'b0;
  logic signed [VAL_W-1:0] sorted_value_o;
  logic [POS_W-1:0]        origin_position_o;
  logic                    final_result_o;

  sample_t feed_q[$];    // items waiting to be driven
  sorted_t held_q[$];    // open batch, kept in sorted order
  sorted_t sorted_q[$];  // results still to come out
  int      feed_wait  = 0;
  int      drain_wait = 0;
  int      cycle_cnt  = 0;
  int      errors     = 0;
  int      accepted   = 0;  // input beats taken by the block

  sort_with_original_indices #(
    .MaxItems(CAP)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sample_value_i,
    .batch_end_i,
    .out_valid_o,
    .out_stall_i,
    .sorted_value_o,
    .origin_position_o,
    .final_result_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    if (errors < 40) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    errors++;
  endtask

  task automatic push_item(input logic signed [VAL_W-1:0] value, input logic last);
    feed_q.push_back('{value, last});
  endtask

  // insert after every held value <= the new one, so ties keep arrival order
  task automatic argsort_insert(input logic signed [VAL_W-1:0] value, input logic last);
    sorted_t entry;
    int      slot;
    int      n;
    entry.value = value;
    entry.pos   = POS_W'(held_q.size());
    entry.fin   = 1'b0;
    slot = held_q.size();
    while (slot > 0 && held_q[slot-1].value > value) slot--;
    held_q.insert(slot, entry);
    if (last || held_q.size() == CAP) begin
      n = held_q.size();
      foreach (held_q[k]) sorted_q.push_back('{held_q[k].value, held_q[k].pos, k == n - 1});
      held_q.delete();
    end
  endtask

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // input side: one beat at a time, random gap between beats
  always @(posedge clk_i or negedge rst_ni) begin : feed_side
    sample_t beat;
    logic    busy;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      sample_value_i <= '0;
      batch_end_i    <= 1'b0;
      feed_wait      <= 0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        argsort_insert(sample_value_i, batch_end_i);
        accepted++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (feed_wait > 0) begin
          feed_wait <= feed_wait - 1;
        end else if (feed_q.size() > 0) begin
          beat = feed_q.pop_front();
          sample_value_i <= beat.value;
          batch_end_i    <= beat.last;
          feed_wait      <= draw_wait(cycle_cnt[10:8] == 3'd2 || cycle_cnt[10:8] == 3'd6);
          busy = 1'b1;
        end
      end
      in_valid_i <= busy;
    end
  end

  // output side: check each result beat, then stall for a random while
  always @(posedge clk_i or negedge rst_ni) begin : drain_side
    sorted_t want;
    int      hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      drain_wait  <= 0;
    end else begin
      hold = drain_wait;
      if (out_valid_o && !out_stall_i) begin
        if (sorted_q.size() == 0) begin
          report($sformatf("unexpected result beat, value %0d", sorted_value_o));
        end else begin
          want = sorted_q.pop_front();
          if (sorted_value_o !== want.value)
            report($sformatf("sorted_value %0d, want %0d", sorted_value_o, want.value));
          if (origin_position_o !== want.pos)
            report($sformatf("origin_position %0d, want %0d", origin_position_o, want.pos));
          if (final_result_o !== want.fin)
            report($sformatf("final_result %0b, want %0b", final_result_o, want.fin));
        end
        hold = draw_wait(cycle_cnt[10:9] == 2'd3);
      end else if (hold > 0) begin
        hold--;
      end
      drain_wait  <= hold;
      out_stall_i <= (hold != 0);
    end
  end

  initial begin : stimulus
    logic signed [VAL_W-1:0] v;
    int len;
    int mode;
    int total;
    int n_items;
    bit flag_full;

    // single-value batches at both extremes
    push_item(MAXV, 1'b1);
    push_item(MINV, 1'b1);
    // mixed signs and extremes
    push_item('0, 1'b0);
    push_item(-1, 1'b0);
    push_item(MAXV, 1'b0);
    push_item(MINV, 1'b1);
    // equal values must come out by arrival
    push_item(5, 1'b0);
    push_item(5, 1'b0);
    push_item(-3, 1'b0);
    push_item(5, 1'b1);
    push_item(MINV, 1'b0);
    push_item(MAXV, 1'b0);
    push_item(MINV, 1'b0);
    push_item(MAXV, 1'b1);
    // reversed pair, then an already sorted run
    push_item(1, 1'b0);
    push_item(-2, 1'b1);
    push_item(-7, 1'b0);
    push_item(7, 1'b0);
    push_item(7, 1'b1);

    // random batches; the first fills the store and closes on capacity alone
    total = 0;
    while (total < 420) begin
      if (total == 0 || $urandom_range(0, 19) == 0) len = CAP;
      else len = $urandom_range(1, 12);
      mode      = $urandom_range(0, 3);
      flag_full = (total != 0) && $urandom_range(0, 1);
      for (int k = 0; k < len; k++) begin
        case (mode)
          0: v = {$urandom, $urandom};
          1: begin
            v = $urandom_range(0, 8);
            v = v - 4;
          end
          2: begin
            case ($urandom_range(0, 4))
              0: v = MINV;
              1: v = MAXV;
              2: v = -1;
              3: v = '0;
              default: v = 1;
            endcase
          end
          default: v = ($urandom_range(0, 1) ? MINV : MAXV) ^ $urandom_range(0, 3);
        endcase
        push_item(v, (k == len - 1) && (len < CAP || flag_full));
      end
      total += len;
    end
    n_items = feed_q.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every beat taken and every predicted result seen
    while (accepted < n_items || sorted_q.size() != 0) @(posedge clk_i);
    repeat (2 * CAP) @(posedge clk_i);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
